FILE: src/dhte_pkg.sv
`default_nettype none
package dhte_pkg;

   localparam int OpW = 2;
   localparam int StatusW = 2;
   localparam int IdW = 31;
   localparam int KeyW = 32;
   localparam int LoadW = 7;
   localparam int StepModW = 10;
   localparam int CsrDataW = 10;
   localparam int CsrIndexW = 1;

   localparam logic [OpW-1:0] OP_INSERT = 2'd0;
   localparam logic [OpW-1:0] OP_LOOKUP = 2'd1;
   localparam logic [OpW-1:0] OP_DELETE = 2'd2;

   localparam logic [StatusW-1:0] RS_OK = 2'd0;
   localparam logic [StatusW-1:0] RS_MISS = 2'd1;
   localparam logic [StatusW-1:0] RS_FULL = 2'd2;

   localparam logic [1:0] ST_EMPTY = 2'd0;
   localparam logic [1:0] ST_FILLED = 2'd1;
   localparam logic [1:0] ST_DELETED = 2'd2;

   localparam logic [CsrIndexW-1:0] CSR_LOAD_PERCENT = 1'd0;
   localparam logic [CsrIndexW-1:0] CSR_STEP_MODULUS = 1'd1;

   localparam logic [LoadW-1:0] LOAD_RESET = 7'd50;
   localparam logic [StepModW-1:0] STEP_MOD_RESET = 10'd97;

   typedef enum logic [4:0] {
      DP_NOP,
      DP_LATCH,
      DP_CLR_WR,
      DP_TH_MUL,
      DP_PR_INIT_GROW,
      DP_PR_INIT_SHRINK,
      DP_PR_DIV,
      DP_PR_NEXTD,
      DP_PR_NEXTC,
      DP_RB_START,
      DP_RB_SCAN_RD,
      DP_RB_LATCH,
      DP_RB_NEXT,
      DP_RB_END,
      DP_RB_PLACE,
      DP_H_DIV1,
      DP_H_DIV2,
      DP_H_DIV3,
      DP_H_END,
      DP_P_RD,
      DP_P_NEXT,
      DP_INS_DONE,
      DP_FULL,
      DP_HIT,
      DP_DEL_WR,
      DP_RSP
   } dp_op_type;

   typedef enum logic [4:0] {
      S_CLR,
      S_IDLE,
      S_TH_MUL,
      S_TH_CMP,
      S_PR_CHK,
      S_PR_WAIT,
      S_RB_CLR,
      S_RB_RD,
      S_RB_EVAL,
      S_RB_NEXT,
      S_H1,
      S_H1W,
      S_H2W,
      S_H3W,
      S_P_RD,
      S_P_EV,
      S_SHR,
      S_RSP
   } ctl_state_type;

   typedef struct packed {
      logic           div_busy;
      logic           rem_zero;
      logic           grow_need;
      logic           shrink_need;
      logic           c_over;
      logic           c_small;
      logic           sq_gt;
      logic           rd_filled;
      logic           rd_empty;
      logic           id_match;
      logic           p_last;
      logic           scan_last;
      logic           clr_last;
      logic           rsp_free;
      logic [OpW-1:0] op;
   } dp_status_type;

endpackage
`default_nettype wire

FILE: src/dhte_ram.sv
`default_nettype none
module dhte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

FILE: src/dhte_ctrl.sv
`default_nettype none
module dhte_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic [1:0]               req_op,
   input  wire dhte_pkg::dp_status_type  sts,
   output      logic                     req_stall,
   output      dhte_pkg::dp_op_type      cmd
);

   dhte_pkg::ctl_state_type state_ff, state_in;
   logic rb_ff, rb_in;
   logic free_search;

   // rebuild placement and insert both look for a free slot
   assign free_search = rb_ff || (sts.op == dhte_pkg::OP_INSERT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dhte_pkg::S_CLR;
         rb_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rb_ff <= rb_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      rb_in = rb_ff;
      unique case (state_ff)
         dhte_pkg::S_CLR: begin
            if (sts.clr_last) state_in = dhte_pkg::S_IDLE;
         end
         dhte_pkg::S_IDLE: begin
            if (req_valid) begin
               unique case (req_op) inside
                  dhte_pkg::OP_INSERT: state_in = dhte_pkg::S_TH_MUL;
                  dhte_pkg::OP_LOOKUP, dhte_pkg::OP_DELETE: state_in = dhte_pkg::S_H1;
                  default: state_in = dhte_pkg::S_RSP;
               endcase
            end
         end
         dhte_pkg::S_TH_MUL: state_in = dhte_pkg::S_TH_CMP;
         dhte_pkg::S_TH_CMP: begin
            state_in = sts.grow_need ? dhte_pkg::S_PR_CHK : dhte_pkg::S_H1;
         end
         dhte_pkg::S_PR_CHK: begin
            if (sts.c_over) begin
               state_in = (sts.op == dhte_pkg::OP_INSERT) ? dhte_pkg::S_H1 : dhte_pkg::S_RSP;
            end else if (sts.c_small) begin
               state_in = dhte_pkg::S_PR_CHK;
            end else if (sts.sq_gt) begin
               state_in = dhte_pkg::S_RB_CLR;
               rb_in = 1'b1;
            end else begin
               state_in = dhte_pkg::S_PR_WAIT;
            end
         end
         dhte_pkg::S_PR_WAIT: begin
            if (!sts.div_busy) state_in = dhte_pkg::S_PR_CHK;
         end
         dhte_pkg::S_RB_CLR: begin
            if (sts.clr_last) state_in = dhte_pkg::S_RB_RD;
         end
         dhte_pkg::S_RB_RD: state_in = dhte_pkg::S_RB_EVAL;
         dhte_pkg::S_RB_EVAL: begin
            state_in = sts.rd_filled ? dhte_pkg::S_H1 : dhte_pkg::S_RB_NEXT;
         end
         dhte_pkg::S_RB_NEXT: begin
            if (sts.scan_last) begin
               rb_in = 1'b0;
               state_in = (sts.op == dhte_pkg::OP_INSERT) ? dhte_pkg::S_H1 : dhte_pkg::S_RSP;
            end else begin
               state_in = dhte_pkg::S_RB_RD;
            end
         end
         dhte_pkg::S_H1: state_in = dhte_pkg::S_H1W;
         dhte_pkg::S_H1W: if (!sts.div_busy) state_in = dhte_pkg::S_H2W;
         dhte_pkg::S_H2W: if (!sts.div_busy) state_in = dhte_pkg::S_H3W;
         dhte_pkg::S_H3W: if (!sts.div_busy) state_in = dhte_pkg::S_P_RD;
         dhte_pkg::S_P_RD: state_in = dhte_pkg::S_P_EV;
         dhte_pkg::S_P_EV: begin
            if (free_search) begin
               if (!sts.rd_filled || sts.p_last) begin
                  state_in = rb_ff ? dhte_pkg::S_RB_NEXT : dhte_pkg::S_RSP;
               end else begin
                  state_in = dhte_pkg::S_P_RD;
               end
            end else if (sts.rd_empty || (sts.rd_filled && sts.id_match) || sts.p_last) begin
               state_in = (sts.op == dhte_pkg::OP_DELETE) ? dhte_pkg::S_SHR : dhte_pkg::S_RSP;
            end else begin
               state_in = dhte_pkg::S_P_RD;
            end
         end
         dhte_pkg::S_SHR: begin
            state_in = sts.shrink_need ? dhte_pkg::S_PR_CHK : dhte_pkg::S_RSP;
         end
         dhte_pkg::S_RSP: begin
            if (sts.rsp_free) state_in = dhte_pkg::S_IDLE;
         end
         default: state_in = dhte_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = dhte_pkg::DP_NOP;
      req_stall = 1'b1;
      unique case (state_ff)
         dhte_pkg::S_CLR: cmd = dhte_pkg::DP_CLR_WR;
         dhte_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) cmd = dhte_pkg::DP_LATCH;
         end
         dhte_pkg::S_TH_MUL: cmd = dhte_pkg::DP_TH_MUL;
         dhte_pkg::S_TH_CMP: begin
            if (sts.grow_need) cmd = dhte_pkg::DP_PR_INIT_GROW;
         end
         dhte_pkg::S_PR_CHK: begin
            if (sts.c_over) cmd = dhte_pkg::DP_NOP;
            else if (sts.c_small) cmd = dhte_pkg::DP_PR_NEXTC;
            else if (sts.sq_gt) cmd = dhte_pkg::DP_RB_START;
            else cmd = dhte_pkg::DP_PR_DIV;
         end
         dhte_pkg::S_PR_WAIT: begin
            if (!sts.div_busy) begin
               cmd = sts.rem_zero ? dhte_pkg::DP_PR_NEXTC : dhte_pkg::DP_PR_NEXTD;
            end
         end
         dhte_pkg::S_RB_CLR: cmd = dhte_pkg::DP_CLR_WR;
         dhte_pkg::S_RB_RD: cmd = dhte_pkg::DP_RB_SCAN_RD;
         dhte_pkg::S_RB_EVAL: begin
            if (sts.rd_filled) cmd = dhte_pkg::DP_RB_LATCH;
         end
         dhte_pkg::S_RB_NEXT: begin
            cmd = sts.scan_last ? dhte_pkg::DP_RB_END : dhte_pkg::DP_RB_NEXT;
         end
         dhte_pkg::S_H1: cmd = dhte_pkg::DP_H_DIV1;
         dhte_pkg::S_H1W: if (!sts.div_busy) cmd = dhte_pkg::DP_H_DIV2;
         dhte_pkg::S_H2W: if (!sts.div_busy) cmd = dhte_pkg::DP_H_DIV3;
         dhte_pkg::S_H3W: if (!sts.div_busy) cmd = dhte_pkg::DP_H_END;
         dhte_pkg::S_P_RD: cmd = dhte_pkg::DP_P_RD;
         dhte_pkg::S_P_EV: begin
            if (free_search) begin
               if (!sts.rd_filled) begin
                  cmd = rb_ff ? dhte_pkg::DP_RB_PLACE : dhte_pkg::DP_INS_DONE;
               end else if (sts.p_last) begin
                  cmd = rb_ff ? dhte_pkg::DP_NOP : dhte_pkg::DP_FULL;
               end else begin
                  cmd = dhte_pkg::DP_P_NEXT;
               end
            end else if (sts.rd_empty) begin
               cmd = dhte_pkg::DP_NOP;
            end else if (sts.rd_filled && sts.id_match) begin
               cmd = (sts.op == dhte_pkg::OP_DELETE) ? dhte_pkg::DP_DEL_WR : dhte_pkg::DP_HIT;
            end else if (!sts.p_last) begin
               cmd = dhte_pkg::DP_P_NEXT;
            end
         end
         dhte_pkg::S_SHR: begin
            if (sts.shrink_need) cmd = dhte_pkg::DP_PR_INIT_SHRINK;
         end
         dhte_pkg::S_RSP: begin
            if (sts.rsp_free) cmd = dhte_pkg::DP_RSP;
         end
         default: cmd = dhte_pkg::DP_NOP;
      endcase
   end

endmodule
`default_nettype wire

FILE: src/dhte_dpath.sv
`default_nettype none
module dhte_dpath #(
   parameter int START_SIZE = 1031,
   parameter int MAX_SIZE = 8192
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire dhte_pkg::dp_op_type       cmd,
   output      dhte_pkg::dp_status_type   sts,
   input  wire logic [1:0]                req_op,
   input  wire logic [30:0]               req_item_id,
   input  wire logic signed [31:0]        req_key_value,
   output      logic                      rsp_valid,
   input  wire logic                      rsp_stall,
   output      logic [1:0]                rsp_status,
   output      logic signed [31:0]        rsp_read_key,
   input  wire logic                      csr_we,
   input  wire logic [0:0]                csr_index,
   input  wire logic [9:0]                csr_wdata
);

   localparam int AW = $clog2(MAX_SIZE);
   localparam int SZW = $clog2(MAX_SIZE + 1);
   localparam int CW = SZW + 1;
   localparam int DVW = (SZW > 10) ? SZW : 10;
   localparam int PW = SZW + 8;
   localparam int RAW = AW + 1;
   localparam int RDEPTH = 2 * (2 ** AW);
   localparam int IW = dhte_pkg::IdW;
   localparam int KW = dhte_pkg::KeyW;

   // control registers
   logic [SZW-1:0] size_ff, fill_ff, tgt_ff;
   logic           bank_ff, cb_ff;
   logic [AW-1:0]  scan_ff;
   logic [6:0]     lp_ff;
   logic [9:0]     sm_ff;
   logic           rsp_valid_ff;
   logic [4:0]     dcnt_ff;

   // working registers
   logic [1:0]     op_ff;
   logic [IW-1:0]  id_ff, hid_ff;
   logic [KW-1:0]  key_ff, hkey_ff, res_key_ff, rsp_key_ff;
   logic [1:0]     res_ff, rsp_status_ff;
   logic [PW-1:0]  prod_ff, fprod_ff;
   logic [CW-1:0]  cand_ff;
   logic [SZW-1:0] dv_ff;
   logic [AW-1:0]  idx_ff, step_ff, pcnt_ff;
   logic [IW-1:0]  dvd_ff;
   logic [DVW-1:0] dvs_ff, rem_ff;

   // memory ports
   logic           st_we, kv_we;
   logic [RAW-1:0] waddr, raddr;
   logic [1:0]     st_wdata, rd_state;
   logic [IW-1:0]  rd_id;
   logic [KW-1:0]  rd_key;

   // divider step
   logic [DVW:0]   trial;
   logic           trial_ge;
   logic [DVW:0]   trial_sub;
   logic           div_start;
   logic [IW-1:0]  start_dvd;
   logic [DVW-1:0] start_dvs;

   logic [AW:0]    idx_sum;
   logic [2*SZW-1:0] dv_sq;

   assign trial = {rem_ff, dvd_ff[IW-1]};
   assign trial_ge = trial >= {1'b0, dvs_ff};
   assign trial_sub = trial - {1'b0, dvs_ff};
   assign idx_sum = {1'b0, idx_ff} + {1'b0, step_ff};
   assign dv_sq = (2*SZW)'(dv_ff) * (2*SZW)'(dv_ff);

   always_comb begin
      div_start = 1'b1;
      start_dvd = hid_ff;
      start_dvs = DVW'(tgt_ff);
      case (cmd)
         dhte_pkg::DP_H_DIV1: begin
            start_dvs = (sm_ff == 10'd0) ? DVW'(1) : DVW'(sm_ff);
         end
         dhte_pkg::DP_H_DIV2: start_dvd = IW'(rem_ff) + IW'(1);
         dhte_pkg::DP_H_DIV3: start_dvd = hid_ff;
         dhte_pkg::DP_PR_DIV: begin
            start_dvd = IW'(cand_ff);
            start_dvs = DVW'(dv_ff);
         end
         default: div_start = 1'b0;
      endcase
   end

   always_comb begin
      st_we = 1'b0;
      kv_we = 1'b0;
      st_wdata = dhte_pkg::ST_FILLED;
      waddr = {cb_ff, idx_ff};
      raddr = {cb_ff, idx_ff};
      case (cmd) inside
         dhte_pkg::DP_CLR_WR: begin
            st_we = 1'b1;
            st_wdata = dhte_pkg::ST_EMPTY;
            waddr = {cb_ff, scan_ff};
         end
         dhte_pkg::DP_RB_PLACE, dhte_pkg::DP_INS_DONE: begin
            st_we = 1'b1;
            kv_we = 1'b1;
         end
         dhte_pkg::DP_DEL_WR: begin
            st_we = 1'b1;
            st_wdata = dhte_pkg::ST_DELETED;
         end
         dhte_pkg::DP_RB_SCAN_RD: raddr = {bank_ff, scan_ff};
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SZW'(START_SIZE);
         fill_ff <= '0;
         tgt_ff <= SZW'(START_SIZE);
         bank_ff <= 1'b0;
         cb_ff <= 1'b0;
         scan_ff <= '0;
         lp_ff <= dhte_pkg::LOAD_RESET;
         sm_ff <= dhte_pkg::STEP_MOD_RESET;
         rsp_valid_ff <= 1'b0;
         dcnt_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               dhte_pkg::CSR_LOAD_PERCENT: lp_ff <= csr_wdata[6:0];
               dhte_pkg::CSR_STEP_MODULUS: sm_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (div_start) dcnt_ff <= 5'(IW);
         else if (dcnt_ff != 5'd0) dcnt_ff <= dcnt_ff - 5'd1;
         case (cmd)
            dhte_pkg::DP_LATCH: begin
               tgt_ff <= size_ff;
               cb_ff <= bank_ff;
            end
            // the scan restarts at slot zero once the clear pass is done
            dhte_pkg::DP_CLR_WR: scan_ff <= sts.clr_last ? '0 : scan_ff + AW'(1);
            dhte_pkg::DP_RB_NEXT: scan_ff <= scan_ff + AW'(1);
            dhte_pkg::DP_RB_START: begin
               tgt_ff <= SZW'(cand_ff);
               cb_ff <= ~bank_ff;
               scan_ff <= '0;
            end
            dhte_pkg::DP_RB_END: begin
               size_ff <= tgt_ff;
               bank_ff <= cb_ff;
               scan_ff <= '0;
            end
            dhte_pkg::DP_INS_DONE: fill_ff <= fill_ff + SZW'(1);
            dhte_pkg::DP_DEL_WR: begin
               if (fill_ff != '0) fill_ff <= fill_ff - SZW'(1);
            end
            dhte_pkg::DP_RSP: rsp_valid_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (div_start) begin
         dvd_ff <= start_dvd;
         dvs_ff <= start_dvs;
         rem_ff <= '0;
      end else if (dcnt_ff != 5'd0) begin
         dvd_ff <= {dvd_ff[IW-2:0], 1'b0};
         rem_ff <= trial_ge ? trial_sub[DVW-1:0] : trial[DVW-1:0];
      end
      case (cmd) inside
         dhte_pkg::DP_LATCH: begin
            op_ff <= req_op;
            id_ff <= req_item_id;
            key_ff <= $unsigned(req_key_value);
            hid_ff <= req_item_id;
            hkey_ff <= $unsigned(req_key_value);
            res_ff <= dhte_pkg::RS_MISS;
            res_key_ff <= '0;
         end
         dhte_pkg::DP_TH_MUL: begin
            prod_ff <= PW'(size_ff) * PW'(lp_ff);
            fprod_ff <= (PW'(fill_ff) + PW'(1)) * PW'(100);
         end
         dhte_pkg::DP_PR_INIT_GROW: begin
            cand_ff <= {size_ff, 1'b0};
            dv_ff <= SZW'(2);
         end
         dhte_pkg::DP_PR_INIT_SHRINK: begin
            cand_ff <= CW'(size_ff >> 1);
            dv_ff <= SZW'(2);
         end
         dhte_pkg::DP_PR_NEXTD: dv_ff <= dv_ff + SZW'(1);
         dhte_pkg::DP_PR_NEXTC: begin
            cand_ff <= cand_ff + CW'(1);
            dv_ff <= SZW'(2);
         end
         dhte_pkg::DP_RB_LATCH: begin
            hid_ff <= rd_id;
            hkey_ff <= rd_key;
         end
         dhte_pkg::DP_RB_END: begin
            hid_ff <= id_ff;
            hkey_ff <= key_ff;
         end
         dhte_pkg::DP_H_DIV3: step_ff <= AW'(rem_ff);
         dhte_pkg::DP_H_END: begin
            idx_ff <= AW'(rem_ff);
            pcnt_ff <= '0;
         end
         dhte_pkg::DP_P_NEXT: begin
            idx_ff <= (idx_sum >= (AW+1)'(tgt_ff)) ? AW'(idx_sum - (AW+1)'(tgt_ff))
                                                   : AW'(idx_sum);
            pcnt_ff <= pcnt_ff + AW'(1);
         end
         dhte_pkg::DP_INS_DONE, dhte_pkg::DP_DEL_WR: res_ff <= dhte_pkg::RS_OK;
         dhte_pkg::DP_FULL: res_ff <= dhte_pkg::RS_FULL;
         dhte_pkg::DP_HIT: begin
            res_ff <= dhte_pkg::RS_OK;
            res_key_ff <= rd_key;
         end
         dhte_pkg::DP_RSP: begin
            rsp_status_ff <= res_ff;
            rsp_key_ff <= res_key_ff;
         end
         default: ;
      endcase
   end

   dhte_ram #(.WIDTH(2), .DEPTH(RDEPTH)) u_state_ram (
      .clock(clock), .we(st_we), .waddr(waddr), .wdata(st_wdata),
      .raddr(raddr), .rdata(rd_state)
   );

   dhte_ram #(.WIDTH(IW), .DEPTH(RDEPTH)) u_id_ram (
      .clock(clock), .we(kv_we), .waddr(waddr), .wdata(hid_ff),
      .raddr(raddr), .rdata(rd_id)
   );

   dhte_ram #(.WIDTH(KW), .DEPTH(RDEPTH)) u_key_ram (
      .clock(clock), .we(kv_we), .waddr(waddr), .wdata(hkey_ff),
      .raddr(raddr), .rdata(rd_key)
   );

   always_comb begin
      sts.div_busy = dcnt_ff != 5'd0;
      sts.rem_zero = rem_ff == '0;
      // fill >= floor(size*lp/100) rewritten without a divide
      sts.grow_need = fprod_ff > prod_ff;
      sts.shrink_need = (fill_ff <= (size_ff >> 2)) &&
                        (32'(size_ff) >= 32'(2 * START_SIZE));
      sts.c_over = 32'(cand_ff) > 32'(MAX_SIZE);
      sts.c_small = cand_ff < CW'(2);
      sts.sq_gt = dv_sq > (2*SZW)'(cand_ff);
      sts.rd_filled = rd_state == dhte_pkg::ST_FILLED;
      sts.rd_empty = rd_state == dhte_pkg::ST_EMPTY;
      sts.id_match = rd_id == hid_ff;
      sts.p_last = SZW'(pcnt_ff) == (tgt_ff - SZW'(1));
      sts.scan_last = SZW'(scan_ff) == (size_ff - SZW'(1));
      sts.clr_last = SZW'(scan_ff) == (tgt_ff - SZW'(1));
      sts.rsp_free = !rsp_valid_ff;
      sts.op = op_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_read_key = $signed(rsp_key_ff);

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= size_ff) else $error("fill count exceeds table size");
   a_probe_range: assert property (@(posedge clock) disable iff (reset)
      cmd == dhte_pkg::DP_P_NEXT |-> idx_ff < AW'(tgt_ff) || 32'(idx_ff) < 32'(tgt_ff))
      else $error("probe index out of range");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> dcnt_ff == 5'd0) else $error("divider restarted while busy");
   a_rsp_slot: assert property (@(posedge clock) disable iff (reset)
      cmd == dhte_pkg::DP_RSP |=> rsp_valid_ff) else $error("result not presented");
`endif

endmodule
`default_nettype wire

FILE: src/double_hash_table_engine.sv
`default_nettype none
// Hash setup is three serial divisions, then each probe reads the slot memories
// and evaluates the slot. Insert first checks the load threshold and may grow;
// delete ends with a shrink check. One item at a time: no new request
// is taken until the previous response has been issued.
// Growth or shrink adds a trial-division prime search, a clear of every new slot
// and a scan of the old table with each filled entry rehashed.
// Reset is synchronous; then bank 0 slot states are cleared, START_SIZE of them.
module double_hash_table_engine #(
   parameter int START_SIZE = 1031,
   parameter int MAX_SIZE = 8192
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic [1:0]         req_op,
   input  wire logic [30:0]        req_item_id,
   input  wire logic signed [31:0] req_key_value,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic [1:0]         rsp_status,
   output      logic signed [31:0] rsp_read_key,
   input  wire logic               csr_we,
   input  wire logic [0:0]         csr_index,
   input  wire logic [9:0]         csr_wdata
);

   dhte_pkg::dp_op_type     cmd;
   dhte_pkg::dp_status_type sts;

   dhte_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_op(req_op),
      .sts(sts), .req_stall(req_stall), .cmd(cmd)
   );

   dhte_dpath #(.START_SIZE(START_SIZE), .MAX_SIZE(MAX_SIZE)) u_dpath (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_op(req_op), .req_item_id(req_item_id), .req_key_value(req_key_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_read_key(rsp_read_key), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

endmodule
`default_nettype wire

FILE: verif/double_hash_table_engine_tb.sv
`timescale 1ns / 1ps
module double_hash_table_engine_tb;

   localparam int START_SIZE = 1031;
   localparam int MAX_SIZE = 8192;
   localparam int WATCHDOG_LIMIT = 1000000;
   localparam logic [dhte_pkg::OpW-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [dhte_pkg::OpW-1:0]     op;
      logic [dhte_pkg::IdW-1:0]     id;
      logic [dhte_pkg::KeyW-1:0]    key;
      bit                           typed;
      logic [dhte_pkg::StatusW-1:0] status;
      logic [dhte_pkg::KeyW-1:0]    read_key;
   } stim_row_type;

   typedef struct {
      logic [dhte_pkg::StatusW-1:0] status;
      logic [dhte_pkg::KeyW-1:0]    read_key;
   } answer_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_op = '0;
   logic [30:0]        req_item_id = '0;
   logic signed [31:0] req_key_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_read_key;
   logic               csr_we = 1'b0;
   logic [0:0]         csr_index = '0;
   logic [9:0]         csr_wdata = '0;

   double_hash_table_engine #(
      .START_SIZE(START_SIZE),
      .MAX_SIZE(MAX_SIZE)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_item_id(req_item_id),
      .req_key_value(req_key_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_read_key(rsp_read_key),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // shadow table
   logic [1:0]                tbl_state [2*MAX_SIZE];
   logic [dhte_pkg::IdW-1:0]  tbl_id [2*MAX_SIZE];
   logic [dhte_pkg::KeyW-1:0] tbl_key [2*MAX_SIZE];
   int unsigned     tbl_size;
   int unsigned     tbl_fill;
   int unsigned     tbl_bank;
   int unsigned     load_pct;
   int unsigned     step_mod;

   answer_type                pending_answers [$];
   logic [dhte_pkg::IdW-1:0]  inserted_ids [$];
   int              errors = 0;
   int              idle_cycles = 0;
   bit              quiet = 1'b0;

   function automatic int unsigned probe_step(int unsigned id);
      return id % ((step_mod != 0) ? step_mod : 1) + 1;
   endfunction

   function automatic bit prime_check(int unsigned n);
      if (n < 2) return 1'b0;
      for (int unsigned d = 2; d * d <= n; d++)
         if (n % d == 0) return 1'b0;
      return 1'b1;
   endfunction

   function automatic int unsigned prime_from(int unsigned n);
      for (int unsigned c = n; c <= MAX_SIZE; c++)
         if (prime_check(c)) return c;
      return 0;
   endfunction

   function automatic int unsigned free_slot(int unsigned bank, int unsigned size,
                                             int unsigned id);
      int unsigned base, idx, stp;
      base = bank * MAX_SIZE;
      idx = id % size;
      stp = probe_step(id) % size;
      for (int unsigned j = 0; j < size; j++) begin
         if (tbl_state[base + idx] != dhte_pkg::ST_FILLED) return idx;
         idx = (idx + stp) % size;
      end
      return size;
   endfunction

   function automatic int unsigned match_slot(int unsigned id);
      int unsigned base, idx, stp;
      base = tbl_bank * MAX_SIZE;
      idx = id % tbl_size;
      stp = probe_step(id) % tbl_size;
      for (int unsigned j = 0; j < tbl_size; j++) begin
         if (tbl_state[base + idx] == dhte_pkg::ST_EMPTY) break;
         if (tbl_state[base + idx] == dhte_pkg::ST_FILLED && tbl_id[base + idx] == id)
            return idx;
         idx = (idx + stp) % tbl_size;
      end
      return tbl_size;
   endfunction

   function automatic void rehash_into(int unsigned target);
      int unsigned ob, nb, k;
      ob = tbl_bank * MAX_SIZE;
      nb = (tbl_bank ^ 1) * MAX_SIZE;
      for (int i = 0; i < MAX_SIZE; i++) tbl_state[nb + i] = dhte_pkg::ST_EMPTY;
      for (int unsigned i = 0; i < tbl_size; i++) begin
         if (tbl_state[ob + i] == dhte_pkg::ST_FILLED) begin
            k = free_slot(tbl_bank ^ 1, target, tbl_id[ob + i]);
            if (k < target) begin
               tbl_state[nb + k] = dhte_pkg::ST_FILLED;
               tbl_id[nb + k] = tbl_id[ob + i];
               tbl_key[nb + k] = tbl_key[ob + i];
            end
         end
      end
      tbl_size = target;
      tbl_bank ^= 1;
   endfunction

   function automatic answer_type table_answer(logic [dhte_pkg::OpW-1:0] op,
                                               logic [dhte_pkg::IdW-1:0] id,
                                               logic [dhte_pkg::KeyW-1:0] key);
      answer_type a;
      int unsigned base, k, ns;
      a.status = dhte_pkg::RS_MISS;
      a.read_key = '0;
      if (op == dhte_pkg::OP_INSERT) begin
         if (tbl_fill >= (tbl_size * load_pct) / 100) begin
            ns = prime_from(tbl_size * 2);
            if (ns != 0) rehash_into(ns);
         end
         base = tbl_bank * MAX_SIZE;
         k = free_slot(tbl_bank, tbl_size, id);
         if (k < tbl_size) begin
            tbl_state[base + k] = dhte_pkg::ST_FILLED;
            tbl_id[base + k] = id;
            tbl_key[base + k] = key;
            tbl_fill++;
            a.status = dhte_pkg::RS_OK;
         end else begin
            a.status = dhte_pkg::RS_FULL;
         end
      end else if (op == dhte_pkg::OP_LOOKUP) begin
         k = match_slot(id);
         if (k < tbl_size) begin
            a.status = dhte_pkg::RS_OK;
            a.read_key = tbl_key[tbl_bank * MAX_SIZE + k];
         end
      end else if (op == dhte_pkg::OP_DELETE) begin
         k = match_slot(id);
         if (k < tbl_size) begin
            tbl_state[tbl_bank * MAX_SIZE + k] = dhte_pkg::ST_DELETED;
            if (tbl_fill != 0) tbl_fill--;
            a.status = dhte_pkg::RS_OK;
         end
         if (tbl_fill <= tbl_size / 4 && tbl_size >= 2 * START_SIZE) begin
            ns = prime_from(tbl_size / 2);
            if (ns != 0) rehash_into(ns);
         end
      end
      return a;
   endfunction

   // one request transfer; expectation queued when valid goes up
   task automatic send_item(stim_row_type row);
      answer_type a;
      while (!quiet && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      a = table_answer(row.op, row.id, row.key);
      if (row.typed) begin
         a.status = row.status;
         a.read_key = row.read_key;
      end
      pending_answers.push_back(a);
      if (row.op == dhte_pkg::OP_INSERT) inserted_ids.push_back(row.id);
      req_valid <= 1'b1;
      req_op <= row.op;
      req_item_id <= row.id;
      req_key_value <= row.key;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, int unsigned value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[9:0];
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == dhte_pkg::CSR_LOAD_PERCENT) load_pct = value & 7'h7f;
      else step_mod = value & 10'h3ff;
   endtask

   function automatic logic [dhte_pkg::IdW-1:0] pick_id();
      logic [31:0] r;
      r = $urandom;
      if (inserted_ids.size() != 0 && $urandom_range(99) < 60)
         return inserted_ids[$urandom_range(inserted_ids.size() - 1)];
      if ($urandom_range(1)) return r[30:0];
      return dhte_pkg::IdW'($urandom_range(4000));
   endfunction

   task automatic run_random(int n, int ins_pct, int del_pct);
      stim_row_type row;
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         row.typed = 1'b0;
         row.key = $urandom;
         row.id = pick_id();
         if (r < ins_pct) row.op = dhte_pkg::OP_INSERT;
         else if (r < ins_pct + del_pct) row.op = dhte_pkg::OP_DELETE;
         else if (r < 97) row.op = dhte_pkg::OP_LOOKUP;
         else row.op = OP_UNUSED;
         send_item(row);
      end
   endtask

   stim_row_type directed [] = '{
      '{dhte_pkg::OP_LOOKUP, 31'd0, 32'd0, 1, dhte_pkg::RS_MISS, 32'd0},
      '{dhte_pkg::OP_DELETE, 31'd5, 32'd0, 1, dhte_pkg::RS_MISS, 32'd0},
      '{OP_UNUSED, 31'h7fffffff, 32'hffffffff, 1, dhte_pkg::RS_MISS, 32'd0},
      '{dhte_pkg::OP_INSERT, 31'd0, 32'h80000000, 1, dhte_pkg::RS_OK, 32'd0},
      '{dhte_pkg::OP_INSERT, 31'h7fffffff, 32'h7fffffff, 1, dhte_pkg::RS_OK, 32'd0},
      '{dhte_pkg::OP_LOOKUP, 31'd0, 32'd0, 1, dhte_pkg::RS_OK, 32'h80000000},
      '{dhte_pkg::OP_LOOKUP, 31'h7fffffff, 32'd0, 1, dhte_pkg::RS_OK, 32'h7fffffff},
      '{dhte_pkg::OP_INSERT, 31'd1031, 32'hffffffff, 0, dhte_pkg::RS_OK, 32'd0},
      '{dhte_pkg::OP_INSERT, 31'd2062, 32'h00000001, 0, dhte_pkg::RS_OK, 32'd0},
      '{dhte_pkg::OP_LOOKUP, 31'd1031, 32'd0, 0, dhte_pkg::RS_OK, 32'd0},
      '{dhte_pkg::OP_DELETE, 31'd0, 32'd0, 0, dhte_pkg::RS_OK, 32'd0},
      '{dhte_pkg::OP_LOOKUP, 31'd0, 32'd0, 0, dhte_pkg::RS_OK, 32'd0},
      '{dhte_pkg::OP_LOOKUP, 31'd2062, 32'd0, 0, dhte_pkg::RS_OK, 32'd0},
      '{dhte_pkg::OP_INSERT, 31'd3093, 32'h12345678, 0, dhte_pkg::RS_OK, 32'd0},
      '{dhte_pkg::OP_INSERT, 31'd3093, 32'h55aa55aa, 0, dhte_pkg::RS_OK, 32'd0},
      '{dhte_pkg::OP_DELETE, 31'd3093, 32'd0, 0, dhte_pkg::RS_OK, 32'd0},
      '{dhte_pkg::OP_LOOKUP, 31'd3093, 32'd0, 0, dhte_pkg::RS_OK, 32'd0},
      '{dhte_pkg::OP_DELETE, 31'd3093, 32'd0, 0, dhte_pkg::RS_OK, 32'd0},
      '{dhte_pkg::OP_DELETE, 31'd3093, 32'd0, 0, dhte_pkg::RS_OK, 32'd0},
      '{dhte_pkg::OP_LOOKUP, 31'h2aaaaaaa, 32'd0, 0, dhte_pkg::RS_OK, 32'd0},
      '{OP_UNUSED, 31'd0, 32'd0, 0, dhte_pkg::RS_OK, 32'd0}
   };

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= quiet ? 1'b0 : ($urandom_range(99) < 9);
         if (rsp_valid && !rsp_stall) begin
            if (pending_answers.size() == 0) begin
               $display("%0t: unexpected response status %0d read_key %h", $time,
                        rsp_status, rsp_read_key);
               errors++;
            end else begin
               if (rsp_status !== pending_answers[0].status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           pending_answers[0].status, rsp_status);
                  errors++;
               end
               if (rsp_read_key !== pending_answers[0].read_key) begin
                  $display("%0t: read_key expected %h actual %h", $time,
                           pending_answers[0].read_key, rsp_read_key);
                  errors++;
               end
               void'(pending_answers.pop_front());
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < 2 * MAX_SIZE; i++) begin
         tbl_state[i] = dhte_pkg::ST_EMPTY;
         tbl_id[i] = '0;
         tbl_key[i] = '0;
      end
      tbl_size = START_SIZE;
      tbl_fill = 0;
      tbl_bank = 0;
      load_pct = dhte_pkg::LOAD_RESET;
      step_mod = dhte_pkg::STEP_MOD_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_item(directed[i]);
      drain();

      // no growth: fill the table until inserts report full
      write_csr(dhte_pkg::CSR_LOAD_PERCENT, 127);
      write_csr(dhte_pkg::CSR_STEP_MODULUS, 1021);
      quiet = 1'b1;
      run_random(300, 100, 0);
      quiet = 1'b0;
      run_random(740, 100, 0);
      run_random(30, 20, 40);
      drain();

      // growth attempted on every insert, step forced to one
      write_csr(dhte_pkg::CSR_LOAD_PERCENT, 0);
      write_csr(dhte_pkg::CSR_STEP_MODULUS, 0);
      run_random(30, 70, 10);
      drain();

      write_csr(dhte_pkg::CSR_LOAD_PERCENT, 50);
      write_csr(dhte_pkg::CSR_STEP_MODULUS, 2);
      run_random(150, 10, 70);
      drain();

      write_csr(dhte_pkg::CSR_LOAD_PERCENT, 1);
      write_csr(dhte_pkg::CSR_STEP_MODULUS, 97);
      run_random(100, 40, 30);
      drain();

      write_csr(dhte_pkg::CSR_LOAD_PERCENT, 100);
      write_csr(dhte_pkg::CSR_STEP_MODULUS, 1021);
      run_random(50, 40, 30);
      drain();

      repeat (100) @(posedge clock);
      if (errors == 0 && pending_answers.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: double_hash_table_engine.f
src/dhte_pkg.sv
src/dhte_ram.sv
src/dhte_ctrl.sv
src/dhte_dpath.sv
src/double_hash_table_engine.sv
verif/double_hash_table_engine_tb.sv
